// ===== design/efpa_pkg.sv =====
// Shared types, widths and status codes of the exact-fit page allocator.
package efpa_pkg;

    localparam int DEF_TABLE_ENTRIES = 256;
    localparam int DEF_PAGE_BYTES    = 4096;

    localparam int CNT_W   = 9;
    localparam int ADDR_W  = 32;
    localparam int STAT_W  = 3;
    localparam int ENTRY_W = 1 + CNT_W + ADDR_W;

    localparam logic [STAT_W-1:0] ST_DONE    = 3'd0;
    localparam logic [STAT_W-1:0] ST_ZERO    = 3'd1;
    localparam logic [STAT_W-1:0] ST_KIND    = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOMATCH = 3'd4;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;
    localparam logic KIND_HEAP = 1'b0;

    typedef struct packed {
        logic              in_use;
        logic [CNT_W-1:0]  count;
        logic [ADDR_W-1:0] addr;
    } t_entry;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ADDR_W-1:0] addr;
    } t_result;

endpackage

// ===== design/efpa_mem.sv =====
// Single-port-write, single-port-read chunk table memory with registered read data.
module efpa_mem #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 42
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/efpa_seq.sv =====
// Request sequencer: clears the table, scans entries, reuses, places or frees chunks.
module efpa_seq #(
    parameter int TABLE_ENTRIES = efpa_pkg::DEF_TABLE_ENTRIES,
    parameter int PAGE_BYTES    = efpa_pkg::DEF_PAGE_BYTES
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_start,
    output logic                                    o_ready,
    input  logic                                    i_action,
    input  logic                                    i_page_kind,
    input  logic [efpa_pkg::CNT_W-1:0]              i_page_count,
    input  logic [efpa_pkg::ADDR_W-1:0]             i_chunk_address,
    input  logic [efpa_pkg::ADDR_W-1:0]             i_heap_top,
    output logic                                    o_res_valid,
    input  logic                                    i_res_ready,
    output efpa_pkg::t_result                       o_res,
    output logic                                    o_mem_we,
    output logic [$clog2(TABLE_ENTRIES)-1:0]        o_mem_waddr,
    output logic [efpa_pkg::ENTRY_W-1:0]            o_mem_wdata,
    output logic                                    o_mem_re,
    output logic [$clog2(TABLE_ENTRIES)-1:0]        o_mem_raddr,
    input  logic [efpa_pkg::ENTRY_W-1:0]            i_mem_rdata
);
    import efpa_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int NP_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int SUM_W = ((NP_W > CNT_W) ? NP_W : CNT_W) + 1;
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [NP_W-1:0]   NP_FULL  = NP_W'(TABLE_ENTRIES);
    localparam logic [SUM_W-1:0]  SUM_MAX  = SUM_W'(TABLE_ENTRIES);
    localparam logic [ADDR_W-1:0] PAGE_C   = ADDR_W'(PAGE_BYTES);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_PLACE = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [IDX_W-1:0]  r_clr, n_clr;
    logic [IDX_W-1:0]  r_rd, n_rd;
    logic              r_hit, n_hit;
    logic [NP_W-1:0]   r_np, n_np;
    t_result           r_res, n_res;

    logic              r_act;
    logic [CNT_W-1:0]  r_cnt;
    logic [ADDR_W-1:0] r_addr;
    logic [SUM_W-1:0]  r_sum;
    logic [ADDR_W-1:0] r_prod;

    t_entry            w_ent;
    t_entry            w_wr;
    logic [IDX_W-1:0]  w_last;
    logic              w_alloc_hit;
    logic              w_free_hit;
    logic [ADDR_W-1:0] w_new_addr;

    assign w_ent       = t_entry'(i_mem_rdata);
    // The scan covers entries 0 through next_page, clipped to the last slot.
    assign w_last      = (r_np >= NP_FULL) ? LAST_IDX : r_np[IDX_W-1:0];
    assign w_alloc_hit = !w_ent.in_use && (w_ent.count == r_cnt);
    assign w_free_hit  = (w_ent.addr == r_addr) && (w_ent.count == r_cnt);
    assign w_new_addr  = i_heap_top - r_prod;

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_rd        = r_rd;
        n_hit       = r_hit;
        n_np        = r_np;
        n_res       = r_res;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_rd;
        w_wr        = '0;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_rd + IDX_W'(1);
        unique case (r_state)
            S_CLEAR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_clr;
                n_clr       = r_clr + IDX_W'(1);
                if (r_clr == LAST_IDX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_hit = 1'b0;
                    n_rd  = '0;
                    n_res = '{status: ST_DONE, addr: '0};
                    if (i_page_count == '0) begin
                        n_res.status = ST_ZERO;
                        n_state      = S_DONE;
                    end else if (i_action == ACT_ALLOC && i_page_kind != KIND_HEAP) begin
                        n_res.status = ST_KIND;
                        n_state      = S_DONE;
                    end else begin
                        o_mem_re    = 1'b1;
                        o_mem_raddr = '0;
                        n_state     = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // Read data belongs to entry r_rd; the next entry is read meanwhile.
                if (r_act == ACT_ALLOC) begin
                    if (w_alloc_hit) begin
                        o_mem_we   = 1'b1;
                        w_wr       = w_ent;
                        w_wr.in_use = 1'b1;
                        n_res      = '{status: ST_DONE, addr: w_ent.addr};
                        n_state    = S_DONE;
                    end else if (r_rd == w_last) begin
                        n_state = S_MUL;
                    end else begin
                        o_mem_re = 1'b1;
                        n_rd     = r_rd + IDX_W'(1);
                    end
                end else begin
                    if (w_free_hit) begin
                        o_mem_we    = 1'b1;
                        w_wr        = w_ent;
                        w_wr.in_use = 1'b0;
                    end
                    n_hit = r_hit | w_free_hit;
                    if (r_rd == w_last) begin
                        n_res.status = (r_hit | w_free_hit) ? ST_DONE : ST_NOMATCH;
                        n_state      = S_DONE;
                    end else begin
                        o_mem_re = 1'b1;
                        n_rd     = r_rd + IDX_W'(1);
                    end
                end
            end
            S_MUL: begin
                if (r_sum > SUM_MAX) begin
                    n_res.status = ST_FULL;
                    n_state      = S_DONE;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_np[IDX_W-1:0];
                w_wr        = '{in_use: 1'b1, count: r_cnt, addr: w_new_addr};
                n_np        = r_sum[NP_W-1:0];
                n_res       = '{status: ST_DONE, addr: w_new_addr};
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        o_mem_wdata = w_wr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_rd    <= '0;
            r_hit   <= 1'b0;
            r_np    <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_rd    <= n_rd;
            r_hit   <= n_hit;
            r_np    <= n_np;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (r_state == S_IDLE && i_start) begin
            r_act  <= i_action;
            r_cnt  <= i_page_count;
            r_addr <= i_chunk_address;
            r_sum  <= SUM_W'(r_np) + SUM_W'(i_page_count);
        end
        if (r_state == S_MUL) begin
            r_prod <= ADDR_W'(r_sum) * PAGE_C;
        end
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule

// ===== design/exact_fit_page_allocator_top.sv =====
// Exact-fit page allocator: configuration register, sequencer, chunk table and output register.
//
// After reset the block clears every entry of its chunk table and accepts
// no request meanwhile; heap_top writes are taken at any time. A request with a zero
// count, or an allocate of a non-heap kind, ends without a table read. Any other
// request reads the table one entry per cycle through the memory's single read port,
// starting at entry 0 and ending at the first exact-fit freed entry (allocate) or at
// entry min(next_page, TABLE_ENTRIES-1) (free, or allocate without reuse). A newly
// placed chunk then takes a multiply, with the table-full check, and a write, and
// every result is handed to the output register. The output register lets the next
// request in while a result still waits to be taken.
module exact_fit_page_allocator_top #(
    parameter int TABLE_ENTRIES = efpa_pkg::DEF_TABLE_ENTRIES,
    parameter int PAGE_BYTES    = efpa_pkg::DEF_PAGE_BYTES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [efpa_pkg::ADDR_W-1:0]      i_cfg_heap_top,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_action,
    input  logic                             i_page_kind,
    input  logic [efpa_pkg::CNT_W-1:0]       i_page_count,
    input  logic [efpa_pkg::ADDR_W-1:0]      i_chunk_address,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [efpa_pkg::STAT_W-1:0]      o_status,
    output logic [efpa_pkg::ADDR_W-1:0]      o_result_address
);
    import efpa_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    logic [ADDR_W-1:0]  r_heap_top;
    logic               r_out_valid;
    t_result            r_out;

    logic               w_seq_ready;
    logic               w_res_valid;
    logic               w_res_ready;
    t_result            w_res;
    logic               w_mem_we;
    logic [IDX_W-1:0]   w_mem_waddr;
    logic [ENTRY_W-1:0] w_mem_wdata;
    logic               w_mem_re;
    logic [IDX_W-1:0]   w_mem_raddr;
    logic [ENTRY_W-1:0] w_mem_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_top <= '0;
        end else if (i_cfg_valid) begin
            r_heap_top <= i_cfg_heap_top;
        end
    end

    efpa_seq #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .PAGE_BYTES    (PAGE_BYTES)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_in_valid & w_seq_ready),
        .o_ready         (w_seq_ready),
        .i_action        (i_action),
        .i_page_kind     (i_page_kind),
        .i_page_count    (i_page_count),
        .i_chunk_address (i_chunk_address),
        .i_heap_top      (r_heap_top),
        .o_res_valid     (w_res_valid),
        .i_res_ready     (w_res_ready),
        .o_res           (w_res),
        .o_mem_we        (w_mem_we),
        .o_mem_waddr     (w_mem_waddr),
        .o_mem_wdata     (w_mem_wdata),
        .o_mem_re        (w_mem_re),
        .o_mem_raddr     (w_mem_raddr),
        .i_mem_rdata     (w_mem_rdata)
    );

    efpa_mem #(
        .DEPTH (TABLE_ENTRIES),
        .WIDTH (ENTRY_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    // The output register takes a new result once the held one has been transferred.
    assign w_res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_in_ready       = w_seq_ready;
    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out.status;
    assign o_result_address = r_out.addr;

endmodule

// ===== design/efpa_chk.sv =====
// Port-level checker for the exact-fit page allocator, bound to the top level.
module efpa_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_ready,
    input logic                             o_out_valid,
    input logic                             i_out_ready,
    input logic [efpa_pkg::STAT_W-1:0]      o_status,
    input logic [efpa_pkg::ADDR_W-1:0]      o_result_address
);
    import efpa_pkg::*;

    // Only one request is in work at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted while another is in work");

    // The table clearing pass keeps requests out right after reset.
    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !o_in_ready)
        else $error("request port ready during table clearing");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_DONE || o_status == ST_ZERO ||
                         o_status == ST_KIND || o_status == ST_FULL ||
                         o_status == ST_NOMATCH))
        else $error("undefined status code");

    // Failed requests and any non-done result carry a zero address.
    a_fail_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_DONE) |-> (o_result_address == '0))
        else $error("nonzero address on failed request");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_status) && $stable(o_result_address)))
        else $error("result changed while stalled");

endmodule

bind exact_fit_page_allocator_top efpa_chk u_efpa_chk (.*);
